@@ rtl/core/aitd_pkg.sv @@
// types, constants and helper functions shared by the apic id topology decoder
`default_nettype none
package aitd_pkg;

	// vendor codes on the vendor input
	localparam logic [1:0] VND_FIRST  = 2'd0;
	localparam logic [1:0] VND_SECOND = 2'd1;

	// family thresholds
	localparam logic [8:0] FAM_FIRST_MIN  = 9'h006;
	localparam logic [8:0] FAM_SECOND_MIN = 9'h00f;
	localparam logic [8:0] FAM_EXT_MIN    = 9'h010;
	localparam logic [8:0] FAM_REORD_END  = 9'h011;
	localparam logic [8:0] FAM_SPLIT_MIN  = 9'h017;

	// leaf thresholds
	localparam logic [31:0] LEAF_CORE_MIN = 32'h0000_0004;
	localparam logic [31:0] LEAF_EXT_MIN  = 32'h8000_0008;

	// queue depths
	localparam int unsigned MID_DEPTH = 2;
	localparam int unsigned OUT_DEPTH = 2;

	// item class decided by the front
	typedef enum logic [1:0] {
		CLS_UNKNOWN,
		CLS_OLD,
		CLS_FULL
	} cls_t;

	// item passed from front to back
	typedef struct packed {
		cls_t        cls;
		logic        reord;
		logic        fam_eq_f;
		logic        split;
		logic [31:0] apic;
		logic [7:0]  lp_max;
		logic [8:0]  core_cnt;
		logic [3:0]  cbits_fix;
		logic [7:0]  thr_m1;
	} mid_item_t;

	// widths worked out in the first back stage
	typedef struct packed {
		cls_t        cls;
		logic        reord;
		logic        fam_eq_f;
		logic [31:0] apic;
		logic [3:0]  smt_w;
		logic [3:0]  core_w;
		logic        err;
	} wid_item_t;

	// result item
	typedef struct packed {
		logic        valid;
		logic [31:0] pkg;
		logic [31:0] core;
		logic [31:0] smt;
		logic        err;
	} res_item_t;

	// ceiling log2 of a 9-bit count, 0 for counts 0 and 1
	function automatic logic [3:0] clog2_9(input logic [8:0] x);
		logic [8:0] y;
		logic [3:0] n;
		y = x - 9'd1;
		n = 4'd0;
		if (x > 9'd1) begin
			for (int i = 0; i < 9; i++) begin
				if (y[i])
					n = 4'(i + 1);
			end
		end
		return n;
	endfunction

	// floor log2 of a nonzero 9-bit count
	function automatic logic [3:0] flog2_9(input logic [8:0] x);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 9; i++) begin
			if (x[i])
				n = 4'(i);
		end
		return n;
	endfunction

	// mask of the low n bits
	function automatic logic [31:0] lo_mask(input logic [4:0] n);
		return (32'h1 << n) - 32'h1;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/aitd_front.sv @@
// front part: classifies an incoming item and works out the per-package counts
`default_nettype none
module aitd_front (
	input  wire logic [1:0]  vendor,
	input  wire logic [8:0]  family,
	input  wire logic [31:0] apic_id,
	input  wire logic        htt_flag,
	input  wire logic [31:0] max_basic_leaf,
	input  wire logic [31:0] max_ext_leaf,
	input  wire logic [7:0]  lp_count,
	input  wire logic [5:0]  cores_minus_one,
	input  wire logic [7:0]  nc_field,
	input  wire logic [3:0]  apic_id_size,
	input  wire logic        nb_cfg_lo,
	input  wire logic [7:0]  threads_minus_one,
	output aitd_pkg::mid_item_t item
);
	import aitd_pkg::*;

	logic first, second;

	// class and family flags
	always_comb begin
		first  = (vendor == VND_FIRST);
		second = (vendor == VND_SECOND);
		item = '0;
		if (!first && !second)
			item.cls = CLS_UNKNOWN;
		else if ((first && family < FAM_FIRST_MIN) || (second && family < FAM_SECOND_MIN))
			item.cls = CLS_OLD;
		else
			item.cls = CLS_FULL;
		item.reord    = second && (family < FAM_REORD_END) && !nb_cfg_lo;
		item.fam_eq_f = (family == FAM_SECOND_MIN);
		item.split    = second && (family >= FAM_SPLIT_MIN);
		item.apic     = apic_id;
		item.thr_m1   = threads_minus_one;
		item.lp_max   = htt_flag ? lp_count : 8'd1;

		// cores per package by vendor and method
		item.cbits_fix = 4'd0;
		if (!second) begin
			item.core_cnt = (max_basic_leaf >= LEAF_CORE_MIN) ?
				({3'd0, cores_minus_one} + 9'd1) : 9'd1;
		end else if (!htt_flag) begin
			item.core_cnt = 9'd1;
		end else if (family < FAM_EXT_MIN || max_ext_leaf < LEAF_EXT_MIN) begin
			item.core_cnt = {1'b0, item.lp_max};
		end else begin
			item.core_cnt  = {1'b0, nc_field} + 9'd1;
			item.cbits_fix = apic_id_size;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/aitd_queue.sv @@
// short queue between the front and the back
`default_nettype none
module aitd_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire aitd_pkg::mid_item_t wr_item,
	output logic                     full,
	input  wire logic                rd_en,
	output aitd_pkg::mid_item_t      rd_item,
	output logic                     rd_valid
);
	import aitd_pkg::*;

	localparam int unsigned PW = $clog2(MID_DEPTH);

	mid_item_t        mem_q [MID_DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;

	assign full     = (cnt_q == (PW+1)'(MID_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wp_q] <= wr_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wp_q <= (wp_q == PW'(MID_DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (rd_en)
				rp_q <= (rp_q == PW'(MID_DEPTH - 1)) ? '0 : rp_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(wr_en) - (PW+1)'(rd_en);
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(MID_DEPTH))
		else $error("mid queue overfilled");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_valid)
		else $error("mid queue read while empty");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!full || rd_en))
		else $error("mid queue written while full");
`endif

endmodule
`default_nettype wire

@@ rtl/core/aitd_back.sv @@
// back part: bit widths, id reordering, field split and the result queue
`default_nettype none
module aitd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire aitd_pkg::mid_item_t in_item,
	input  wire logic                in_valid,
	output logic                     in_pop,
	output logic                     empty,
	input  wire logic                pop,
	output aitd_pkg::res_item_t      res
);
	import aitd_pkg::*;

	localparam int unsigned PW = $clog2(OUT_DEPTH);

	wid_item_t     wid;
	wid_item_t     wid_s1;
	logic          v_s1;
	res_item_t     res_c;
	res_item_t     out_q [OUT_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   ocnt_q;
	logic          out_pop, room, s1_adv;

	logic [8:0]  fit;
	logic [17:0] lim;
	logic [3:0]  smt_a, smt_b, cb_a;
	logic        lt;

	// widths: thread width from the smallest k with lp < core_cnt * (2^k + 1)
	always_comb begin
		fit = '0;
		for (int k = 0; k < 9; k++) begin
			lim    = ({9'd0, in_item.core_cnt} << k) + {9'd0, in_item.core_cnt};
			fit[k] = ({10'd0, in_item.lp_max} < lim);
		end
		smt_a = 4'd8;
		for (int k = 8; k >= 0; k--) begin
			if (fit[k])
				smt_a = 4'(k);
		end
		lt = ({1'b0, in_item.lp_max} < in_item.core_cnt);
		if (lt || in_item.core_cnt == 9'd0)
			smt_a = 4'd0;
		cb_a = (in_item.cbits_fix != 4'd0) ? in_item.cbits_fix : clog2_9(in_item.core_cnt);
		smt_b = flog2_9({1'b0, in_item.thr_m1} + 9'd1);

		wid          = '0;
		wid.cls      = in_item.cls;
		wid.apic     = in_item.apic;
		wid.fam_eq_f = in_item.fam_eq_f;
		unique case (in_item.cls)
			CLS_FULL: begin
				wid.reord  = in_item.reord;
				wid.err    = lt;
				wid.smt_w  = smt_a;
				wid.core_w = cb_a;
				// newer families split threads per core out of the core field
				if (in_item.split) begin
					if (smt_a != 4'd0)
						wid.err = 1'b1;
					wid.smt_w = smt_b;
					if (smt_b > cb_a) begin
						wid.err    = 1'b1;
						wid.core_w = 4'd0;
					end else begin
						wid.core_w = cb_a - smt_b;
					end
				end
			end
			default: begin
				wid.reord = 1'b0;
			end
		endcase
	end

	// handshake between stage one and the result queue
	assign out_pop = pop && (ocnt_q != '0);
	assign room    = (ocnt_q != (PW+1)'(OUT_DEPTH)) || out_pop;
	assign s1_adv  = v_s1 && room;
	assign in_pop  = in_valid && (!v_s1 || room);

	// stage one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_pop)
			v_s1 <= 1'b1;
		else if (s1_adv)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_pop)
			wid_s1 <= wid;
	end

	// old-family reordering, then the split into package, core and thread
	always_comb begin
		logic [31:0] a;
		logic [31:0] node;
		logic [4:0]  total;
		node = {29'd0, wid_s1.apic[2:0]};
		a    = wid_s1.apic;
		if (wid_s1.reord) begin
			if (wid_s1.fam_eq_f)
				a = (wid_s1.apic >> wid_s1.core_w) | (node << wid_s1.core_w);
			else
				a = (wid_s1.apic >> 5) | (node << 2);
		end
		total      = {1'b0, wid_s1.smt_w} + {1'b0, wid_s1.core_w};
		res_c.valid = (wid_s1.cls != CLS_UNKNOWN);
		res_c.pkg   = a >> total;
		res_c.core  = (a >> wid_s1.smt_w) & lo_mask({1'b0, wid_s1.core_w});
		res_c.smt   = a & lo_mask({1'b0, wid_s1.smt_w});
		res_c.err   = wid_s1.err;
		if (wid_s1.cls == CLS_UNKNOWN)
			res_c = '0;
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (s1_adv)
			out_q[wp_q] <= res_c;
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			ocnt_q <= '0;
		end else begin
			if (s1_adv)
				wp_q <= (wp_q == PW'(OUT_DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (out_pop)
				rp_q <= (rp_q == PW'(OUT_DEPTH - 1)) ? '0 : rp_q + PW'(1);
			ocnt_q <= ocnt_q + (PW+1)'(s1_adv) - (PW+1)'(out_pop);
		end
	end

	assign empty = (ocnt_q == '0);
	assign res   = out_q[rp_q];

`ifndef SYNTHESIS
	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= (PW+1)'(OUT_DEPTH))
		else $error("result queue overfilled");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !room) |=> (v_s1 && $stable(wid_s1)))
		else $error("stage one item lost while stalled");
	a_unknown_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && wid_s1.cls == CLS_UNKNOWN) |-> (!res_c.valid && !res_c.err))
		else $error("unknown vendor gave a valid result");
`endif

endmodule
`default_nettype wire

@@ rtl/core/apic_id_topology_decode_unit.sv @@
// top level of the apic id topology decoder
//
// Input channel: an item (vendor, family, apic id and identification fields)
// is taken at a rising edge with push high and full low. Result channel: the
// oldest result sits on topology_valid, pkg_id, core_id, smt_id and
// consistency_error while empty is low, and leaves at an edge with pop high.
// Path: the front feeds the two-entry mid queue, then one width stage, then
// the two-entry result queue, where the result waits on the outputs.
// Throughput: one item per cycle while results are popped; the widths are
// found before the stage one register, the reordering and barrel shifts after.
// When the receiver stalls, the result queue fills, then the width stage
// holds, then the mid queue fills and full rises; nothing is dropped.
// Reset clears the queue pointers, fill counts and stage one valid bit; the
// block is ready once reset is released, and the queue storage is not reset.
`default_nettype none
module apic_id_topology_decode_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  vendor,
	input  wire logic [8:0]  family,
	input  wire logic [31:0] apic_id,
	input  wire logic        htt_flag,
	input  wire logic [31:0] max_basic_leaf,
	input  wire logic [31:0] max_ext_leaf,
	input  wire logic [7:0]  lp_count,
	input  wire logic [5:0]  cores_minus_one,
	input  wire logic [7:0]  nc_field,
	input  wire logic [3:0]  apic_id_size,
	input  wire logic        nb_cfg_lo,
	input  wire logic [7:0]  threads_minus_one,
	output logic             empty,
	input  wire logic        pop,
	output logic             topology_valid,
	output logic [31:0]      pkg_id,
	output logic [31:0]      core_id,
	output logic [31:0]      smt_id,
	output logic             consistency_error
);
	import aitd_pkg::*;

	mid_item_t front_item, mid_item;
	res_item_t res;
	logic      mid_valid, mid_pop, wr_en;

	assign wr_en = push && !full;

	// classify and count
	aitd_front u_front (
		.vendor            (vendor),
		.family            (family),
		.apic_id           (apic_id),
		.htt_flag          (htt_flag),
		.max_basic_leaf    (max_basic_leaf),
		.max_ext_leaf      (max_ext_leaf),
		.lp_count          (lp_count),
		.cores_minus_one   (cores_minus_one),
		.nc_field          (nc_field),
		.apic_id_size      (apic_id_size),
		.nb_cfg_lo         (nb_cfg_lo),
		.threads_minus_one (threads_minus_one),
		.item              (front_item)
	);

	// decoupling queue
	aitd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_item  (front_item),
		.full     (full),
		.rd_en    (mid_pop),
		.rd_item  (mid_item),
		.rd_valid (mid_valid)
	);

	// widths and field split
	aitd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (mid_item),
		.in_valid (mid_valid),
		.in_pop   (mid_pop),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

	assign topology_valid    = res.valid;
	assign pkg_id            = res.pkg;
	assign core_id           = res.core;
	assign smt_id            = res.smt;
	assign consistency_error = res.err;

endmodule
`default_nettype wire

@@ tb/sv/apic_id_topology_decode_unit_tb.sv @@
// self-checking testbench for the apic id topology decoder
module apic_id_topology_decode_unit_tb;
	import aitd_pkg::*;

	localparam logic [1:0] VND_OTHER = 2'd2;
	localparam int unsigned RANDOM_QUERIES = 1250;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// one query as offered on the input side, with the gap before it
	typedef struct {
		logic [1:0]  vendor;
		logic [8:0]  family;
		logic [31:0] apic_id;
		logic        htt;
		logic [31:0] max_basic;
		logic [31:0] max_ext;
		logic [7:0]  lp_count;
		logic [5:0]  cores_m1;
		logic [7:0]  nc;
		logic [3:0]  id_size;
		logic        nb_lo;
		logic [7:0]  thr_m1;
		int unsigned lead;
	} query_t;

	// one decoded topology as seen on the result side
	typedef struct {
		logic        valid;
		logic [31:0] pkg;
		logic [31:0] core;
		logic [31:0] smt;
		logic        err;
	} topo_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic [1:0]  vendor = '0;
	logic [8:0]  family = '0;
	logic [31:0] apic_id = '0;
	logic        htt_flag = 1'b0;
	logic [31:0] max_basic_leaf = '0;
	logic [31:0] max_ext_leaf = '0;
	logic [7:0]  lp_count = '0;
	logic [5:0]  cores_minus_one = '0;
	logic [7:0]  nc_field = '0;
	logic [3:0]  apic_id_size = '0;
	logic        nb_cfg_lo = 1'b0;
	logic [7:0]  threads_minus_one = '0;
	logic        full;
	logic        empty;
	logic        topology_valid;
	logic [31:0] pkg_id;
	logic [31:0] core_id;
	logic [31:0] smt_id;
	logic        consistency_error;

	query_t      pending_queries[$];
	topo_t       topologies_due[$];

	int unsigned mismatches = 0;
	int unsigned queries_taken = 0;
	int unsigned topologies_seen = 0;
	int unsigned flagged_queries = 0;
	int unsigned split_queries = 0;
	int unsigned full_cycles = 0;
	int unsigned cycles = 0;

	apic_id_topology_decode_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.vendor            (vendor),
		.family            (family),
		.apic_id           (apic_id),
		.htt_flag          (htt_flag),
		.max_basic_leaf    (max_basic_leaf),
		.max_ext_leaf      (max_ext_leaf),
		.lp_count          (lp_count),
		.cores_minus_one   (cores_minus_one),
		.nc_field          (nc_field),
		.apic_id_size      (apic_id_size),
		.nb_cfg_lo         (nb_cfg_lo),
		.threads_minus_one (threads_minus_one),
		.empty             (empty),
		.pop               (pop),
		.topology_valid    (topology_valid),
		.pkg_id            (pkg_id),
		.core_id           (core_id),
		.smt_id            (smt_id),
		.consistency_error (consistency_error)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// number of significant bits, 0 for a zero value
	function automatic int unsigned bit_length(input logic [31:0] v);
		int unsigned n;
		n = 0;
		for (int i = 0; i < 32; i++) begin
			if (v[i])
				n = i + 1;
		end
		return n;
	endfunction

	// ceiling log2 of a count, with counts 0 and 1 both giving 0
	function automatic int unsigned count_width(input logic [31:0] x);
		if (x == 0)
			return 0;
		return bit_length(x - 32'd1);
	endfunction

	// expected topology for one query
	function automatic topo_t decode_topology(input query_t q);
		topo_t       t;
		logic        second;
		logic [31:0] lp_max;
		logic [31:0] core_cnt;
		logic [31:0] id;
		logic [31:0] node;
		int unsigned smt_w;
		int unsigned core_w;
		int unsigned total;
		t = '{valid: 1'b0, pkg: '0, core: '0, smt: '0, err: 1'b0};
		second = (q.vendor == VND_SECOND);
		if (q.vendor != VND_FIRST && !second)
			return t;
		t.valid = 1'b1;
		// old families hand the id through as the package
		if ((!second && q.family < FAM_FIRST_MIN) || (second && q.family < FAM_SECOND_MIN)) begin
			t.pkg = q.apic_id;
			return t;
		end
		id = q.apic_id;
		core_w = 0;
		lp_max = q.htt ? 32'(q.lp_count) : 32'd1;
		// cores per package by vendor and method
		if (!second) begin
			core_cnt = (q.max_basic >= LEAF_CORE_MIN) ? 32'(q.cores_m1) + 32'd1 : 32'd1;
		end else if (!q.htt) begin
			core_cnt = 32'd1;
		end else if (q.family < FAM_EXT_MIN || q.max_ext < LEAF_EXT_MIN) begin
			core_cnt = lp_max;
		end else begin
			core_cnt = 32'(q.nc) + 32'd1;
			if (q.id_size != 0)
				core_w = 32'(q.id_size);
		end
		if (lp_max < core_cnt) begin
			t.err = 1'b1;
			smt_w = 0;
		end else begin
			smt_w = count_width((core_cnt == 0) ? 32'd0 : lp_max / core_cnt);
		end
		if (core_w == 0)
			core_w = count_width(core_cnt);
		// old-family node bit reordering
		if (second && q.family < FAM_REORD_END && !q.nb_lo) begin
			node = {29'd0, id[2:0]};
			if (q.family == FAM_SECOND_MIN)
				id = (id >> core_w) | (node << core_w);
			else
				id = (id >> 5) | (node << 2);
		end
		// newer families split threads per core out of the core field
		if (second && q.family >= FAM_SPLIT_MIN) begin
			if (smt_w != 0)
				t.err = 1'b1;
			smt_w = bit_length(32'(q.thr_m1) + 32'd1) - 1;
			if (smt_w > core_w) begin
				t.err = 1'b1;
				core_w = 0;
			end else begin
				core_w = core_w - smt_w;
			end
		end
		// shifts of 32 or more give 0 and the mask then covers all bits
		total = smt_w + core_w;
		t.pkg = (total != 0) ? id >> total : id;
		if (core_w != 0)
			t.core = (id >> smt_w) & ((32'd1 << core_w) - 32'd1);
		if (smt_w != 0)
			t.smt = id & ((32'd1 << smt_w) - 32'd1);
		return t;
	endfunction

	function automatic query_t make_query(input logic [1:0] v, input logic [8:0] f,
			input logic [31:0] apic, input logic htt, input logic [31:0] basic,
			input logic [31:0] ext, input logic [7:0] lp, input logic [5:0] cm1,
			input logic [7:0] nc, input logic [3:0] size, input logic nb,
			input logic [7:0] thr);
		query_t q;
		q = '{vendor: v, family: f, apic_id: apic, htt: htt, max_basic: basic,
			max_ext: ext, lp_count: lp, cores_m1: cm1, nc: nc, id_size: size,
			nb_lo: nb, thr_m1: thr, lead: 0};
		return q;
	endfunction

	// mostly well-formed queries per vendor, the rest raw noise
	function automatic query_t random_query();
		query_t      q;
		int unsigned pick;
		int unsigned span;
		int unsigned lp;
		pick = $urandom_range(0, 99);
		q = make_query(2'($urandom_range(0, 2)), 9'($urandom_range(0, 270)), $urandom,
			1'($urandom), $urandom, $urandom, 8'($urandom), 6'($urandom), 8'($urandom),
			4'($urandom), 1'($urandom), 8'($urandom));
		if (pick < 15)
			return q;
		q.htt = ($urandom_range(0, 9) != 0);
		span = ($urandom_range(0, 1) != 0) ? 7 : 63;
		if (pick < 55) begin
			q.vendor = VND_FIRST;
			q.family = 9'($urandom_range(FAM_FIRST_MIN, 270));
			q.max_basic = ($urandom_range(0, 9) != 0) ?
				$urandom_range(LEAF_CORE_MIN, 32'h20) : $urandom_range(0, 3);
			q.cores_m1 = 6'($urandom_range(0, span));
			lp = (32'(q.cores_m1) + 1) << $urandom_range(0, 2);
		end else begin
			q.vendor = VND_SECOND;
			case ($urandom_range(0, 4))
				0: q.family = FAM_SECOND_MIN;
				1: q.family = FAM_EXT_MIN;
				2: q.family = 9'($urandom_range(FAM_REORD_END, FAM_SPLIT_MIN - 1));
				3: q.family = 9'($urandom_range(FAM_SPLIT_MIN, 9'h01a));
				default: q.family = 9'($urandom_range(FAM_SPLIT_MIN, 270));
			endcase
			q.max_ext = ($urandom_range(0, 4) != 0) ?
				$urandom_range(LEAF_EXT_MIN, 32'h8000_0028) :
				$urandom_range(32'h8000_0000, LEAF_EXT_MIN - 1);
			q.nc = 8'($urandom_range(0, (span == 7) ? 15 : 255));
			q.thr_m1 = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
			q.id_size = ($urandom_range(0, 2) == 0) ? 4'd0 :
				4'(count_width(32'(q.nc) + 1) + $urandom_range(0, 1));
			lp = (32'(q.nc) + 1) * (32'(q.thr_m1) + 1);
		end
		if (lp > 255)
			lp = 255;
		q.lp_count = (pick >= 90) ? 8'($urandom) : 8'(lp);
		return q;
	endfunction

	// compare one field and report every difference
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
		end
	endtask

	// input side: offers pending queries after their gaps
	query_t      offered;
	logic        push_on = 1'b0;
	logic        staged = 1'b0;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (push_on && !full) begin
				topologies_due.push_back(decode_topology(offered));
				queries_taken++;
				if (topologies_due[$].err)
					flagged_queries++;
				if (offered.vendor == VND_SECOND && offered.family >= FAM_SPLIT_MIN)
					split_queries++;
				push_on = 1'b0;
			end
			if (!push_on && !staged && pending_queries.size() != 0) begin
				offered = pending_queries.pop_front();
				gap_left = offered.lead;
				staged = 1'b1;
			end
			if (staged) begin
				if (gap_left == 0) begin
					staged = 1'b0;
					push_on = 1'b1;
					vendor <= offered.vendor;
					family <= offered.family;
					apic_id <= offered.apic_id;
					htt_flag <= offered.htt;
					max_basic_leaf <= offered.max_basic;
					max_ext_leaf <= offered.max_ext;
					lp_count <= offered.lp_count;
					cores_minus_one <= offered.cores_m1;
					nc_field <= offered.nc;
					apic_id_size <= offered.id_size;
					nb_cfg_lo <= offered.nb_lo;
					threads_minus_one <= offered.thr_m1;
				end else begin
					gap_left--;
				end
			end
			push <= push_on;
		end
	end

	// result side: checks each item taken and stalls between them
	logic        pop_on = 1'b0;
	int unsigned stall_left = 0;
	topo_t       oldest;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop_on && !empty) begin
				if (topologies_due.size() == 0) begin
					mismatches++;
					$error("topology item with nothing expected: pkg 0x%08h", pkg_id);
				end else begin
					oldest = topologies_due.pop_front();
					check_field("topology_valid", 32'(oldest.valid), 32'(topology_valid));
					check_field("pkg_id", oldest.pkg, pkg_id);
					check_field("core_id", oldest.core, core_id);
					check_field("smt_id", oldest.smt, smt_id);
					check_field("consistency_error", 32'(oldest.err), 32'(consistency_error));
				end
				topologies_seen++;
				pop_on = 1'b0;
				// long hold-offs back the queues up into the input
				if (topologies_seen == 300 || topologies_seen == 900)
					stall_left = 150;
				else if ((topologies_seen / 128) % 4 == 2)
					stall_left = 0;
				else
					stall_left = $urandom_range(0, 13);
			end
			if (!pop_on) begin
				if (stall_left == 0)
					pop_on = 1'b1;
				else
					stall_left--;
			end
			pop <= pop_on;
		end
	end

	// cycle budget and input backpressure count
	always @(posedge clk) begin
		cycles++;
		if (arst_n && full)
			full_cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		query_t q;
		// unknown vendor with the family at 270 and every other field at its top
		pending_queries.push_back(make_query(VND_OTHER, 9'd270, '1, 1'b1, '1, '1, 8'hff,
			6'h3f, 8'hff, 4'hf, 1'b1, 8'hff));
		// old families pass the id through
		pending_queries.push_back(make_query(VND_FIRST, 9'd5, '1, 1'b1, 32'd11,
			32'h8000_0008, 8'd16, 6'd7, 8'd0, 4'd0, 1'b0, 8'd0));
		pending_queries.push_back(make_query(VND_SECOND, 9'h00e, 32'h1234_5678, 1'b1, 32'd1,
			32'h8000_0008, 8'd4, 6'd0, 8'd3, 4'd2, 1'b0, 8'd0));
		// first vendor: no htt, normal, lp count too small, too-low basic leaf
		pending_queries.push_back(make_query(VND_FIRST, 9'd6, 32'h0000_00ff, 1'b0, 32'd3,
			32'd0, 8'd0, 6'd3, 8'd0, 4'd0, 1'b0, 8'd0));
		pending_queries.push_back(make_query(VND_FIRST, 9'd6, 32'h0000_0a5d, 1'b1, 32'd11,
			32'd0, 8'd16, 6'd7, 8'd0, 4'd0, 1'b0, 8'd0));
		pending_queries.push_back(make_query(VND_FIRST, 9'd6, 32'hdead_beef, 1'b1, 32'd4,
			32'd0, 8'd0, 6'd3, 8'd0, 4'd0, 1'b0, 8'd0));
		pending_queries.push_back(make_query(VND_FIRST, 9'd6, 32'hdead_beef, 1'b1, 32'd0,
			32'd0, 8'd0, 6'd0, 8'd0, 4'd0, 1'b0, 8'd0));
		pending_queries.push_back(make_query(VND_FIRST, 9'd270, '1, 1'b1, '1, '1, 8'hff,
			6'h3f, 8'hff, 4'hf, 1'b1, 8'hff));
		pending_queries.push_back(make_query(VND_FIRST, 9'd6, 32'd0, 1'b0, 32'd0, 32'd0,
			8'd0, 6'd0, 8'd0, 4'd0, 1'b0, 8'd0));
		// second vendor legacy path with a zero count, then family f reordering
		pending_queries.push_back(make_query(VND_SECOND, 9'h010, 32'h8765_4321, 1'b1, 32'd1,
			32'h8000_0007, 8'd0, 6'd0, 8'd5, 4'd3, 1'b0, 8'd0));
		pending_queries.push_back(make_query(VND_SECOND, 9'h00f, 32'hffff_fff5, 1'b1, 32'd1,
			32'h8000_0008, 8'd0, 6'd0, 8'd0, 4'd0, 1'b0, 8'd0));
		pending_queries.push_back(make_query(VND_SECOND, 9'h00f, 32'h0000_00f3, 1'b1, 32'd1,
			32'h8000_0008, 8'd4, 6'd0, 8'd3, 4'd0, 1'b0, 8'd0));
		// family 10h reordering on and off, then 11h, past the reordering range
		pending_queries.push_back(make_query(VND_SECOND, 9'h010, 32'hcafe_f00d, 1'b1, 32'd5,
			32'h8000_0008, 8'd8, 6'd0, 8'd3, 4'd0, 1'b0, 8'd0));
		pending_queries.push_back(make_query(VND_SECOND, 9'h010, 32'hcafe_f00d, 1'b1, 32'd5,
			32'h8000_0008, 8'd8, 6'd0, 8'd3, 4'd0, 1'b1, 8'd0));
		pending_queries.push_back(make_query(VND_SECOND, 9'h011, 32'h0000_0137, 1'b1, 32'd5,
			32'h8000_001e, 8'd8, 6'd0, 8'd3, 4'd3, 1'b0, 8'd0));
		// thread split: leftover thread width, clean split, thread bits exceed core bits
		pending_queries.push_back(make_query(VND_SECOND, 9'h017, 32'h0000_1fff, 1'b1, 32'd13,
			32'h8000_001e, 8'd32, 6'd0, 8'd15, 4'd4, 1'b0, 8'd1));
		pending_queries.push_back(make_query(VND_SECOND, 9'h017, 32'h0000_1fff, 1'b1, 32'd13,
			32'h8000_001e, 8'd16, 6'd0, 8'd15, 4'd4, 1'b0, 8'd1));
		pending_queries.push_back(make_query(VND_SECOND, 9'h019, 32'haaaa_5555, 1'b1, 32'd13,
			32'h8000_0020, 8'd1, 6'd0, 8'd0, 4'd0, 1'b0, 8'hff));
		pending_queries.push_back(make_query(VND_SECOND, 9'd270, 32'h5555_aaaa, 1'b0, 32'd13,
			32'h8000_0020, 8'd2, 6'd0, 8'd1, 4'd1, 1'b1, 8'd0));
		pending_queries.push_back(make_query(VND_SECOND, 9'h017, '1, 1'b1, '1, '1, 8'hff,
			6'h3f, 8'hff, 4'hf, 1'b0, 8'd0));
		// random part: stretches without gaps between stretches with gaps
		for (int i = 0; i < RANDOM_QUERIES; i++) begin
			q = random_query();
			q.lead = ((i / 100) % 4 == 1) ? 0 : $urandom_range(0, 13);
			pending_queries.push_back(q);
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_queries.size() != 0 || staged || push_on)
			@(posedge clk);
		while (topologies_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("decoded %0d queries, %0d results checked, %0d flagged inconsistent, %0d on the thread split",
			queries_taken, topologies_seen, flagged_queries, split_queries);
		$display("input held off by a full queue on %0d cycles, %0d mismatches",
			full_cycles, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
